FILE: design/stl_pkg.sv
package stl_pkg;

    // Lexer mode
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_HALTED = 2'd3
    } t_mode;

    // Token kind on each result item
    typedef enum logic [1:0] {
        KIND_IDENT  = 2'd0,
        KIND_NUMBER = 2'd1,
        KIND_LPAREN = 2'd2,
        KIND_RPAREN = 2'd3
    } t_kind;

    // Error code on each result item
    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_LEADING_ZERO = 2'd1,
        ERR_UNRECOGNISED = 2'd2,
        ERR_RESERVED     = 2'd3
    } t_err;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] lexeme;
        logic       byte_valid;
        logic       token_end;
        t_err       err;
        logic       last;
    } t_result;

    // Outcome of handling a byte from idle
    typedef struct packed {
        logic    has;
        t_result res;
        t_mode   mode;
    } t_idle_dec;

    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [7:0] ChLParen = 8'h28;
    localparam logic [7:0] ChRParen = 8'h29;
    localparam logic [7:0] ChZero   = 8'h30;
    localparam logic [7:0] ChNine   = 8'h39;
    localparam logic [7:0] ChDot    = 8'h2E;
    localparam logic [7:0] ChAt     = 8'h40;
    localparam logic [7:0] ChTilde  = 8'h7E;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= ChZero) && (c <= ChNine);
    endfunction

    function automatic logic is_ident_start(input logic [7:0] c);
        logic alpha;
        logic sym;
        alpha = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
        sym   = (c == 8'h21) || (c == 8'h24) || (c == 8'h25) || (c == 8'h26) ||
                (c == 8'h2A) || (c == 8'h2F) || (c == 8'h3A) || (c == 8'h3C) ||
                (c == 8'h3D) || (c == 8'h3E) || (c == 8'h3F) || (c == 8'h5E) ||
                (c == 8'h5F) || (c == ChTilde) || (c == 8'h2B) || (c == 8'h2D);
        return alpha || sym;
    endfunction

    function automatic logic is_ident_more(input logic [7:0] c);
        return is_ident_start(c) || (c == ChDot) || (c == ChAt);
    endfunction

    // Decode one byte as if no token were open
    function automatic t_idle_dec idle_decode(input logic [7:0] c);
        t_idle_dec d;
        d.has = 1'b1;
        d.mode = MODE_IDLE;
        d.res = '{kind: KIND_IDENT, lexeme: 8'd0, byte_valid: 1'b0,
                  token_end: 1'b0, err: ERR_NONE, last: 1'b0};
        if (is_space(c)) begin
            d.has = 1'b0;
        end else if (c == ChLParen) begin
            d.res.kind = KIND_LPAREN;
            d.res.token_end = 1'b1;
        end else if (c == ChRParen) begin
            d.res.kind = KIND_RPAREN;
            d.res.token_end = 1'b1;
        end else if (is_ident_start(c)) begin
            d.res.lexeme = c;
            d.res.byte_valid = 1'b1;
            d.mode = MODE_IDENT;
        end else if (c == ChZero) begin
            d.res.err = ERR_LEADING_ZERO;
            d.mode = MODE_HALTED;
        end else if (is_digit(c)) begin
            d.res.kind = KIND_NUMBER;
            d.res.lexeme = c;
            d.res.byte_valid = 1'b1;
            d.mode = MODE_NUMBER;
        end else begin
            d.res.err = ERR_UNRECOGNISED;
            d.mode = MODE_HALTED;
        end
        return d;
    endfunction

endpackage

FILE: design/sexpr_token_lexer_unit.sv
// Byte-serial S-expression lexer. One source byte (or an end-of-source
// mark) is taken per cycle while the input is not stalled, and split into
// identifier, number and parenthesis tokens; lexeme bytes stream out one per
// result item, and a byte that closes one token and opens another gives two
// items. Every accepted byte is decoded in the cycle it is accepted and its
// items are written into a four-entry result queue, so the first item
// appears in the cycle after acceptance when the queue was empty. The queue
// drains one item per cycle while the output is not stalled, which sets the
// sustained rate: one byte per cycle while each byte gives at most one item.
// The input stalls whenever fewer than two queue entries are free. After an
// error item the block gives no further items until reset.
module sexpr_token_lexer_unit
    import stl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_source_byte,
    input  logic       i_end_of_source,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_token_kind,
    output logic [7:0] o_lexeme_byte,
    output logic       o_byte_valid,
    output logic       o_token_end,
    output logic [1:0] o_error_code,
    output logic       o_last_of_run
);

    t_mode             r_mode;
    t_mode             n_mode;
    t_result           r_queue [QDepth];
    logic [QPtrW-1:0]  r_wptr;
    logic [QPtrW-1:0]  r_rptr;
    logic [QCntW-1:0]  r_count;
    logic [QCntW-1:0]  n_count;

    logic              in_acc;
    logic              out_acc;
    t_idle_dec         idle_dec;
    logic              tok_open;
    logic              tok_cont;
    t_kind             open_kind;
    logic [1:0]        push_n;
    t_result           res0;
    t_result           res1;
    t_result           head;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // Shared decode of the current byte
    assign idle_dec  = idle_decode(i_source_byte);
    assign tok_open  = (r_mode == MODE_IDENT) || (r_mode == MODE_NUMBER);
    assign open_kind = (r_mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
    assign tok_cont  = !i_end_of_source &&
                       ((r_mode == MODE_IDENT) ? is_ident_more(i_source_byte)
                                               : is_digit(i_source_byte));

    // Next mode
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            MODE_IDLE: begin
                if (!i_end_of_source) n_mode = idle_dec.mode;
            end
            MODE_IDENT, MODE_NUMBER: begin
                if (!tok_cont) begin
                    n_mode = i_end_of_source ? MODE_IDLE : idle_dec.mode;
                end
            end
            MODE_HALTED: n_mode = MODE_HALTED;
        endcase
    end

    // Result items for the current byte
    always_comb begin
        push_n = 2'd0;
        res0   = idle_dec.res;
        res1   = idle_dec.res;
        unique case (r_mode)
            MODE_IDLE: begin
                if (!i_end_of_source && idle_dec.has) push_n = 2'd1;
            end
            MODE_IDENT, MODE_NUMBER: begin
                res0 = '{kind: open_kind, lexeme: 8'd0, byte_valid: 1'b0,
                         token_end: 1'b1, err: ERR_NONE, last: 1'b0};
                if (tok_cont) begin
                    res0.lexeme     = i_source_byte;
                    res0.byte_valid = 1'b1;
                    res0.token_end  = 1'b0;
                    push_n = 2'd1;
                end else if (!i_end_of_source && idle_dec.has) begin
                    push_n = 2'd2;
                end else begin
                    push_n = 2'd1;
                end
            end
            MODE_HALTED: push_n = 2'd0;
        endcase
        // mark the final item of this byte
        res0.last = (push_n == 2'd1);
        res1.last = 1'b1;
    end

    assign n_count = r_count + QCntW'(in_acc ? push_n : 2'd0) - QCntW'(out_acc);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (in_acc) begin
                r_mode <= n_mode;
                r_wptr <= r_wptr + QPtrW'(push_n);
            end
            if (out_acc) r_rptr <= r_rptr + 1'b1;
            r_count <= n_count;
        end
    end

    // Write result items into the queue
    always_ff @(posedge i_clk) begin
        if (in_acc && (push_n != 2'd0)) r_queue[r_wptr] <= res0;
        if (in_acc && (push_n == 2'd2)) r_queue[r_wptr + 1'b1] <= res1;
    end

    // Hold off input unless two entries are free
    assign o_in_stall  = (r_count > QCntW'(QDepth - 2));
    assign o_out_valid = (r_count != '0);

    assign head          = r_queue[r_rptr];
    assign o_token_kind  = head.kind;
    assign o_lexeme_byte = head.lexeme;
    assign o_byte_valid  = head.byte_valid;
    assign o_token_end   = head.token_end;
    assign o_error_code  = head.err;
    assign o_last_of_run = head.last;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCntW'(QDepth))
        else $error("result queue overfilled");

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_HALTED) |=> (r_mode == MODE_HALTED))
        else $error("left halted mode without reset");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_error_code != ERR_NONE)) |->
            (o_last_of_run && (r_mode == MODE_HALTED)))
        else $error("error item not last or mode not halted");

    a_byte_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_byte_valid) |-> !o_token_end)
        else $error("lexeme byte item also marks token end");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> (r_count <= $past(r_count)))
        else $error("queue grew without an accepted item");
`endif

endmodule

FILE: dv/testbench.sv
module testbench;
    import stl_pkg::*;

    localparam int QuietLimit = 4000;
    localparam int DrainCycles = 16;
    localparam int HoldCycles = 300;
    localparam int ReportMax = 10;

    typedef struct {
        logic [7:0] ch;
        logic       eos;
    } t_src_item;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [7:0] i_source_byte = 8'h00;
    logic       i_end_of_source = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [1:0] o_token_kind;
    logic [7:0] o_lexeme_byte;
    logic       o_byte_valid;
    logic       o_token_end;
    logic [1:0] o_error_code;
    logic       o_last_of_run;

    t_src_item  source_q[$];
    t_result    lexed_items[$];
    t_mode      lex_state = MODE_IDLE;
    int         mismatches = 0;
    int         seen_tokens = 0;
    int         quiet_cycles = 0;
    logic       src_taken = 1'b0;
    int         tx_gap = 0;
    int         tx_run = 0;
    int         rx_gap = 0;
    int         rx_run = 0;
    int         hold_left = 0;

    sexpr_token_lexer_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_source_byte   (i_source_byte),
        .i_end_of_source (i_end_of_source),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_token_kind    (o_token_kind),
        .o_lexeme_byte   (o_lexeme_byte),
        .o_byte_valid    (o_byte_valid),
        .o_token_end     (o_token_end),
        .o_error_code    (o_error_code),
        .o_last_of_run   (o_last_of_run)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Character classes of the source language
    function automatic logic blank_char(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic logic dec_char(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic sym_head(input logic [7:0] c);
        logic letter;
        letter = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
        return letter || (c == "!") || (c == "$") || (c == "%") || (c == "&") ||
               (c == "*") || (c == "/") || (c == ":") || (c == "<") || (c == "=") ||
               (c == ">") || (c == "?") || (c == "^") || (c == "_") ||
               (c == ChTilde) || (c == "+") || (c == "-");
    endfunction

    function automatic logic sym_tail(input logic [7:0] c);
        return sym_head(c) || (c == ChDot) || (c == ChAt);
    endfunction

    function automatic t_result blank_token();
        t_result r;
        r.kind = KIND_IDENT;
        r.lexeme = 8'h00;
        r.byte_valid = 1'b0;
        r.token_end = 1'b0;
        r.err = ERR_NONE;
        r.last = 1'b0;
        return r;
    endfunction

    // Handle a byte with no token open
    task automatic open_token(input logic [7:0] c);
        t_result r;
        r = blank_token();
        if (blank_char(c)) return;
        if (c == ChLParen) begin
            r.kind = KIND_LPAREN;
            r.token_end = 1'b1;
        end else if (c == ChRParen) begin
            r.kind = KIND_RPAREN;
            r.token_end = 1'b1;
        end else if (sym_head(c)) begin
            r.lexeme = c;
            r.byte_valid = 1'b1;
            lex_state = MODE_IDENT;
        end else if (c == ChZero) begin
            r.err = ERR_LEADING_ZERO;
            lex_state = MODE_HALTED;
        end else if (dec_char(c)) begin
            r.kind = KIND_NUMBER;
            r.lexeme = c;
            r.byte_valid = 1'b1;
            lex_state = MODE_NUMBER;
        end else begin
            r.err = ERR_UNRECOGNISED;
            lex_state = MODE_HALTED;
        end
        lexed_items.push_back(r);
    endtask

    // Work out the tokens caused by one accepted item
    task automatic lex_byte(input logic [7:0] c, input logic eos);
        t_result r;
        int first;
        logic more;
        first = lexed_items.size();
        r = blank_token();
        if (lex_state == MODE_IDENT || lex_state == MODE_NUMBER) begin
            r.kind = (lex_state == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
            more = (lex_state == MODE_IDENT) ? sym_tail(c) : dec_char(c);
            if (!eos && more) begin
                r.lexeme = c;
                r.byte_valid = 1'b1;
                lexed_items.push_back(r);
            end else begin
                r.token_end = 1'b1;
                lexed_items.push_back(r);
                lex_state = MODE_IDLE;
                if (!eos) open_token(c);
            end
        end else if (lex_state == MODE_IDLE && !eos) begin
            open_token(c);
        end
        // Mark the final item of this run
        if (lexed_items.size() > first) begin
            r = lexed_items.pop_back();
            r.last = 1'b1;
            lexed_items.push_back(r);
        end
    endtask

    task automatic check_token();
        t_result want;
        if (lexed_items.size() == 0) begin
            mismatches++;
            if (mismatches <= ReportMax)
                $display("unexpected item: kind %0d byte %h bv %b end %b err %0d last %b",
                         o_token_kind, o_lexeme_byte, o_byte_valid, o_token_end,
                         o_error_code, o_last_of_run);
            return;
        end
        want = lexed_items.pop_front();
        if (o_token_kind !== want.kind || o_lexeme_byte !== want.lexeme ||
            o_byte_valid !== want.byte_valid || o_token_end !== want.token_end ||
            o_error_code !== want.err || o_last_of_run !== want.last) begin
            mismatches++;
            if (mismatches <= ReportMax) begin
                $display("mismatch at item %0d", seen_tokens);
                $display("  expected kind %0d byte %h bv %b end %b err %0d last %b",
                         want.kind, want.lexeme, want.byte_valid, want.token_end,
                         want.err, want.last);
                $display("  actual   kind %0d byte %h bv %b end %b err %0d last %b",
                         o_token_kind, o_lexeme_byte, o_byte_valid, o_token_end,
                         o_error_code, o_last_of_run);
            end
        end
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 90) return $urandom_range(3, 8);
        return $urandom_range(20, 50);
    endfunction

    task automatic queue_byte(input logic [7:0] c);
        t_src_item it;
        it.ch = c;
        it.eos = 1'b0;
        source_q.push_back(it);
    endtask

    task automatic queue_eos();
        t_src_item it;
        it.ch = 8'($urandom_range(0, 255));
        it.eos = 1'b1;
        source_q.push_back(it);
    endtask

    task automatic queue_text(input string s);
        for (int k = 0; k < s.len(); k++) queue_byte(s[k]);
    endtask

    // Source driver: take accepted items, then drive the next at the falling edge
    always begin
        @(posedge i_clk);
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            lex_byte(i_source_byte, i_end_of_source);
            src_taken = 1'b1;
        end
        @(negedge i_clk);
        if (!i_in_valid || src_taken) begin
            if (src_taken) begin
                if (tx_run > 0) begin
                    tx_run--;
                end else if ($urandom_range(0, 99) < 3) begin
                    tx_run = 40;
                end else if ($urandom_range(0, 99) < 45) begin
                    tx_gap = gap_len();
                end
            end
            src_taken = 1'b0;
            if (!i_rst_n || tx_gap > 0 || source_q.size() == 0) begin
                if (tx_gap > 0) tx_gap--;
                i_in_valid = 1'b0;
                i_source_byte = 8'($urandom_range(0, 255));
                i_end_of_source = 1'($urandom_range(0, 1));
            end else begin
                t_src_item it;
                it = source_q.pop_front();
                i_in_valid = 1'b1;
                i_source_byte = it.ch;
                i_end_of_source = it.eos;
            end
        end
    end

    // Token monitor: check at the rising edge, choose stall at the falling edge
    always begin
        @(posedge i_clk);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            check_token();
            seen_tokens++;
            if (seen_tokens == 150 || seen_tokens == 500) hold_left = HoldCycles;
        end
        @(negedge i_clk);
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else if (rx_gap > 0) begin
            i_out_stall = 1'b1;
            rx_gap--;
        end else begin
            i_out_stall = 1'b0;
            if (rx_run > 0) begin
                rx_run--;
            end else if ($urandom_range(0, 99) < 3) begin
                rx_run = 60;
            end else if ($urandom_range(0, 99) < 30) begin
                rx_gap = gap_len();
            end
        end
    end

    // Abort when neither side moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QuietLimit) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        string head_set;
        string tail_set;
        logic [7:0] blanks[4];
        logic [7:0] c;
        int live;
        int pick;
        int n;

        head_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz!$%&*/:<=>?^_~+-";
        tail_set = {head_set, ".@"};
        blanks = '{8'h20, 8'h09, 8'h0A, 8'h0D};

        // Directed: parens, symbols, 0 in a number, close by blank/paren/digit/eos
        queue_text("(Az.@~! 901)");
        queue_byte(8'h09);
        queue_text("a7");
        queue_byte(8'h0A);
        queue_text("b");
        queue_eos();
        queue_eos();
        queue_text("5");
        queue_eos();
        queue_byte(8'h0D);
        queue_text("x(3)");

        // Random well-formed source text
        live = 0;
        while (live < 850) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                queue_byte(head_set[$urandom_range(0, head_set.len() - 1)]);
                n = $urandom_range(0, 6);
                for (int k = 0; k < n; k++)
                    queue_byte(tail_set[$urandom_range(0, tail_set.len() - 1)]);
                live += n + 1;
            end else if (pick < 60) begin
                queue_byte(8'($urandom_range(49, 57)));
                n = $urandom_range(0, 5);
                for (int k = 0; k < n; k++) queue_byte(8'($urandom_range(48, 57)));
                live += n + 1;
            end else if (pick < 75) begin
                queue_byte($urandom_range(0, 1) ? ChLParen : ChRParen);
                live++;
            end else if (pick < 95) begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++) queue_byte(blanks[$urandom_range(0, 3)]);
            end else begin
                queue_eos();
            end
        end

        // One error halts the block for good, so it comes last
        queue_eos();
        if ($urandom_range(0, 1)) begin
            queue_byte(ChZero);
        end else begin
            do begin
                c = 8'($urandom_range(0, 255));
            end while (blank_char(c) || c == ChLParen || c == ChRParen ||
                       sym_head(c) || dec_char(c));
            queue_byte(c);
        end
        // Ignored after the halt: extremes and random noise
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_eos();
        for (int k = 0; k < 20; k++) begin
            if ($urandom_range(0, 3) == 0) queue_eos();
            else queue_byte(8'($urandom_range(0, 255)));
        end

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        while (source_q.size() != 0 || i_in_valid || lexed_items.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (lexed_items.size() != 0) begin
            mismatches++;
            $display("%0d expected items never arrived", lexed_items.size());
        end
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
